FILE: src/fpc_pkg.sv
`timescale 1ns / 1ps

package fpc_pkg;

    localparam int CHUNK_BYTES = 256;
    localparam int POS_W = $clog2(CHUNK_BYTES + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] REQ_DATA    = 2'd0;
    localparam logic [1:0] REQ_ADVANCE = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [1:0] PH_DATA    = 2'd0;
    localparam logic [1:0] PH_PAD     = 2'd1;
    localparam logic [1:0] PH_TRAILER = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
    localparam logic [7:0]  FILL_BYTE   = 8'hFF;
    localparam logic [7:0]  HDR_DATA    = 8'h00;
    localparam logic [7:0]  HDR_TRAILER = 8'h01;

    typedef struct packed {
        logic       hdr;
        logic [7:0] value;
        logic       valid;
        logic       kind;
        logic       first;
        logic       last;
        logic       done;
        logic       rejected;
    } cmd_t;

    typedef struct packed {
        logic [7:0] value;
        logic       valid;
        logic       kind;
        logic       first;
        logic       last;
        logic       done;
        logic       status;
        logic       lor;
    } res_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

FILE: src/fpc_front.sv
`timescale 1ns / 1ps

module fpc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [1:0]       req_type,
    input  logic [7:0]       data_byte,
    output fpc_pkg::cmd_t    cmd
);
    import fpc_pkg::*;

    logic [31:0]      crc_reg, crc_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       phase_reg, phase_next;

    logic [1:0]  eff_phase;
    logic        at_end;
    logic [31:0] fin;
    logic [31:0] fin_sh;
    logic [1:0]  sel;

    assign fin    = crc_reg ^ CRC_ONES;
    assign sel    = pos_reg[1:0] - 2'd1;
    assign fin_sh = fin >> {sel, 3'b000};

    always_comb
    begin
        crc_next   = crc_reg;
        pos_next   = pos_reg;
        phase_next = phase_reg;
        cmd        = '0;
        eff_phase  = phase_reg;
        at_end     = 1'b0;
        if (req_type == REQ_RESTART)
        begin
            crc_next   = CRC_ONES;
            pos_next   = '0;
            phase_next = PH_DATA;
        end
        else if (req_type == REQ_DATA && phase_reg == PH_DATA)
        begin
            at_end    = (pos_reg == POS_W'(CHUNK_BYTES - 1));
            crc_next  = crc_byte(crc_reg, data_byte);
            pos_next  = at_end ? '0 : pos_reg + POS_W'(1);
            cmd.hdr   = (pos_reg == '0);
            cmd.value = data_byte;
            cmd.valid = 1'b1;
            cmd.last  = at_end;
        end
        else if (req_type == REQ_ADVANCE && phase_reg != PH_DONE)
        begin
            if (phase_reg == PH_DATA)
            begin
                eff_phase = (pos_reg != '0) ? PH_PAD : PH_TRAILER;
            end
            cmd.valid = 1'b1;
            if (eff_phase == PH_PAD)
            begin
                at_end     = (pos_reg == POS_W'(CHUNK_BYTES - 1));
                pos_next   = at_end ? '0 : pos_reg + POS_W'(1);
                phase_next = at_end ? PH_TRAILER : PH_PAD;
                cmd.value  = FILL_BYTE;
                cmd.last   = at_end;
            end
            else
            begin
                at_end     = (pos_reg == POS_W'(CHUNK_BYTES));
                pos_next   = at_end ? '0 : pos_reg + POS_W'(1);
                phase_next = at_end ? PH_DONE : PH_TRAILER;
                if (pos_reg == '0)
                begin
                    cmd.value = HDR_TRAILER;
                end
                else if (pos_reg <= POS_W'(4))
                begin
                    cmd.value = fin_sh[7:0];
                end
                else
                begin
                    cmd.value = FILL_BYTE;
                end
                cmd.kind  = 1'b1;
                cmd.first = (pos_reg == '0);
                cmd.last  = at_end;
                cmd.done  = at_end;
            end
        end
        else
        begin
            cmd.rejected = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_ONES;
            pos_reg   <= '0;
            phase_reg <= PH_DATA;
        end
        else if (accept)
        begin
            crc_reg   <= crc_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
        end
    end

endmodule

FILE: src/fpc_queue.sv
`timescale 1ns / 1ps

module fpc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fpc_pkg::cmd_t push_data,
    input  logic          pop,
    output fpc_pkg::cmd_t head,
    output logic          not_empty,
    output logic          full
);
    import fpc_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QPTR_W + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

FILE: src/fpc_back.sv
`timescale 1ns / 1ps

module fpc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  fpc_pkg::cmd_t head,
    input  logic          not_empty,
    output logic          pop,
    input  logic          rsp_stall,
    output logic          rsp_valid,
    output fpc_pkg::res_t res
);
    import fpc_pkg::*;

    logic rsp_valid_reg;
    logic hdr_sent_reg, hdr_sent_next;
    res_t res_reg, res_next;
    logic load;
    logic emit_hdr;

    assign load     = !rsp_valid_reg || !rsp_stall;
    assign emit_hdr = head.hdr && !hdr_sent_reg;
    assign pop      = load && not_empty && !emit_hdr;

    always_comb
    begin
        res_next      = res_reg;
        hdr_sent_next = hdr_sent_reg;
        if (load && not_empty)
        begin
            if (emit_hdr)
            begin
                res_next.value  = HDR_DATA;
                res_next.valid  = 1'b1;
                res_next.kind   = 1'b0;
                res_next.first  = 1'b1;
                res_next.last   = 1'b0;
                res_next.done   = 1'b0;
                res_next.status = 1'b0;
                res_next.lor    = 1'b0;
                hdr_sent_next   = 1'b1;
            end
            else
            begin
                res_next.value  = head.value;
                res_next.valid  = head.valid;
                res_next.kind   = head.kind;
                res_next.first  = head.first;
                res_next.last   = head.last;
                res_next.done   = head.done;
                res_next.status = head.rejected;
                res_next.lor    = 1'b1;
                hdr_sent_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            hdr_sent_reg  <= 1'b0;
        end
        else
        begin
            hdr_sent_reg <= hdr_sent_next;
            if (load)
            begin
                rsp_valid_reg <= not_empty;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign res       = res_reg;

endmodule

FILE: src/firmware_packetizer_crc32_unit.sv
`timescale 1ns / 1ps

// Packetizer for a firmware image with a running reflected CRC-32. Each request is
// taken while the four-entry queue between the request side and the result side
// has room, and the result side delivers one result per cycle while rsp_stall is
// low, so an image byte that opens a chunk yields two results (header plus byte)
// and every other request one. The CRC is updated one byte per cycle on the request
// side while req_stall is low. A result passes through the queue and the result
// register to the outputs, and a stalled output lets the queue fill until req_stall rises.

module firmware_packetizer_crc32_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [1:0] req_type,
    input  logic [7:0] data_byte,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       packet_kind,
    output logic       first_of_packet,
    output logic       last_of_packet,
    output logic       image_done,
    output logic       status,
    output logic       last_of_run
);
    import fpc_pkg::*;

    logic accept;
    cmd_t cmd;
    cmd_t head;
    logic not_empty;
    logic full;
    logic pop;
    res_t res;

    assign req_stall = full;
    assign accept    = req_valid && !full;

    fpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (req_type),
        .data_byte (data_byte),
        .cmd       (cmd)
    );

    fpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (full)
    );

    fpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .res       (res)
    );

    assign out_byte        = res.value;
    assign byte_valid      = res.valid;
    assign packet_kind     = res.kind;
    assign first_of_packet = res.first;
    assign last_of_packet  = res.last;
    assign image_done      = res.done;
    assign status          = res.status;
    assign last_of_run     = res.lor;

endmodule

FILE: tb/firmware_packetizer_crc32_unit_tb.sv
`timescale 1ns / 1ps

module firmware_packetizer_crc32_unit_tb;
    import fpc_pkg::*;

    localparam int LIMIT = 400000;
    localparam int RANDOM_REQS = 1600;
    localparam int CALM_TAIL = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 20;

    localparam logic [1:0] REQ_ILLEGAL = 2'd3;
    localparam logic ST_OK = 1'b0;
    localparam logic ST_REJECT = 1'b1;
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_TRAILER = 1'b1;

    class packet_stream_board;
        logic [31:0] crc_acc;
        logic [POS_W-1:0] position;
        logic [1:0] phase;
        res_t expected_bytes[$];
        int errors;

        function new();
            restart();
            errors = 0;
        endfunction

        function void restart();
            crc_acc = CRC_ONES;
            position = '0;
            phase = PH_DATA;
        endfunction

        // Bit-serial form of the reflected CRC-32 update.
        function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            logic fb;
            r = c;
            for (int i = 0; i < 8; i++)
            begin
                fb = r[0] ^ b[i];
                r = r >> 1;
                if (fb)
                begin
                    r = r ^ CRC_POLY;
                end
            end
            return r;
        endfunction

        function void push(logic [7:0] v, logic valid, logic kind, logic first,
                           logic last, logic done, logic st, logic lor);
            res_t r;
            r.value = v;
            r.valid = valid;
            r.kind = kind;
            r.first = first;
            r.last = last;
            r.done = done;
            r.status = st;
            r.lor = lor;
            expected_bytes.push_back(r);
        endfunction

        function void note_request(logic [1:0] req, logic [7:0] b);
            logic [31:0] fin;
            logic [7:0] v;
            logic last;
            logic [POS_W-1:0] p;
            if (req == REQ_RESTART)
            begin
                restart();
                push(8'h00, 1'b0, KIND_DATA, 1'b0, 1'b0, 1'b0, ST_OK, 1'b1);
            end
            else if (req == REQ_DATA && phase == PH_DATA)
            begin
                if (position == 0)
                begin
                    push(HDR_DATA, 1'b1, KIND_DATA, 1'b1, 1'b0, 1'b0, ST_OK, 1'b0);
                end
                crc_acc = crc_step(crc_acc, b);
                position = position + 1'b1;
                last = (position >= CHUNK_BYTES);
                if (last)
                begin
                    position = '0;
                end
                push(b, 1'b1, KIND_DATA, 1'b0, last, 1'b0, ST_OK, 1'b1);
            end
            else if (req == REQ_ADVANCE && phase != PH_DONE)
            begin
                if (phase == PH_DATA)
                begin
                    phase = (position != 0) ? PH_PAD : PH_TRAILER;
                end
                if (phase == PH_PAD)
                begin
                    position = position + 1'b1;
                    last = (position >= CHUNK_BYTES);
                    if (last)
                    begin
                        position = '0;
                        phase = PH_TRAILER;
                    end
                    push(FILL_BYTE, 1'b1, KIND_DATA, 1'b0, last, 1'b0, ST_OK, 1'b1);
                end
                else
                begin
                    p = position;
                    fin = crc_acc ^ CRC_ONES;
                    last = (p >= CHUNK_BYTES);
                    if (p == 0)
                    begin
                        v = HDR_TRAILER;
                    end
                    else if (p <= 4)
                    begin
                        v = 8'(fin >> (8 * (p - 1)));
                    end
                    else
                    begin
                        v = FILL_BYTE;
                    end
                    if (last)
                    begin
                        position = '0;
                        phase = PH_DONE;
                    end
                    else
                    begin
                        position = p + 1'b1;
                    end
                    push(v, 1'b1, KIND_TRAILER, (p == 0), last, last, ST_OK, 1'b1);
                end
            end
            else
            begin
                push(8'h00, 1'b0, KIND_DATA, 1'b0, 1'b0, 1'b0, ST_REJECT, 1'b1);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        task report(string field, logic [7:0] got, logic [7:0] want);
            $display("ERROR %s: got 'h%0h, expected 'h%0h", field, got, want);
            errors++;
        endtask

        task check_result(res_t got);
            res_t want;
            if (expected_bytes.size() == 0)
            begin
                report("result with nothing expected, out_byte", got.value, 8'h00);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.value !== want.value) report("out_byte", got.value, want.value);
            if (got.valid !== want.valid)
                report("byte_valid", 8'(got.valid), 8'(want.valid));
            if (got.kind !== want.kind)
                report("packet_kind", 8'(got.kind), 8'(want.kind));
            if (got.first !== want.first)
                report("first_of_packet", 8'(got.first), 8'(want.first));
            if (got.last !== want.last)
                report("last_of_packet", 8'(got.last), 8'(want.last));
            if (got.done !== want.done)
                report("image_done", 8'(got.done), 8'(want.done));
            if (got.status !== want.status)
                report("status", 8'(got.status), 8'(want.status));
            if (got.lor !== want.lor)
                report("last_of_run", 8'(got.lor), 8'(want.lor));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic [1:0] req_type = REQ_DATA;
    logic [7:0] data_byte = 8'h00;
    logic rsp_stall = 1'b0;
    logic req_stall;
    logic rsp_valid;
    logic [7:0] out_byte;
    logic byte_valid;
    logic packet_kind;
    logic first_of_packet;
    logic last_of_packet;
    logic image_done;
    logic status;
    logic last_of_run;

    packet_stream_board board;
    bit calm = 1'b0;
    bit hold_armed = 1'b0;
    logic hold_rx = 1'b0;
    int cycle_count = 0;
    int sent = 0;
    int target = 0;

    firmware_packetizer_crc32_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_type(req_type),
        .data_byte(data_byte),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .out_byte(out_byte),
        .byte_valid(byte_valid),
        .packet_kind(packet_kind),
        .first_of_packet(first_of_packet),
        .last_of_packet(last_of_packet),
        .image_done(image_done),
        .status(status),
        .last_of_run(last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
    begin : result_side
        res_t got;
        int stall_left;
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            got.value = out_byte;
            got.valid = byte_valid;
            got.kind = packet_kind;
            got.first = first_of_packet;
            got.last = last_of_packet;
            got.done = image_done;
            got.status = status;
            got.lor = last_of_run;
            board.check_result(got);
        end
        if (hold_rx)
        begin
            rsp_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // One long hold-off on the result side so that the internal queue fills up.
    initial
    begin
        wait (hold_armed);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    task automatic send_req(logic [1:0] t, logic [7:0] b);
        int gap;
        gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type <= t;
        data_byte <= b;
        do @(posedge clk); while (req_stall !== 1'b0);
        board.note_request(t, b);
        sent++;
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    // An image is cut short once the request count reaches the target.
    task automatic run_image(int len, int advances, int extras);
        send_req(REQ_RESTART, 8'($urandom));
        repeat (len) if (sent < target) send_req(REQ_DATA, 8'($urandom));
        repeat (advances) if (sent < target) send_req(REQ_ADVANCE, 8'($urandom));
        repeat (extras) if (sent < target) send_req(2'($urandom), 8'($urandom));
    endtask

    initial
    begin
        int len;
        int full;
        bit drained;
        board = new();
        drained = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty image: the trailer follows at once and carries the CRC of no data.
        send_req(REQ_ADVANCE, 8'h00);
        send_req(REQ_ADVANCE, 8'hFF);
        send_req(REQ_DATA, 8'h12);
        send_req(REQ_ILLEGAL, 8'hFF);
        send_req(REQ_RESTART, 8'hFF);
        send_req(REQ_DATA, 8'h00);
        send_req(REQ_DATA, 8'hFF);
        send_req(REQ_DATA, 8'h80);
        send_req(REQ_DATA, 8'h01);
        send_req(REQ_ILLEGAL, 8'h00);
        send_req(REQ_ADVANCE, 8'h00);
        send_req(REQ_ADVANCE, 8'hAA);
        send_req(REQ_DATA, 8'h55);
        send_req(REQ_RESTART, 8'h00);
        send_req(REQ_RESTART, 8'h00);
        send_req(REQ_DATA, 8'hA5);
        send_req(REQ_RESTART, 8'h3C);

        target = sent + RANDOM_REQS;
        hold_armed = 1'b1;
        while (sent < target)
        begin
            if (sent >= target - CALM_TAIL)
            begin
                calm = 1'b1;
            end
            case ($urandom_range(0, 5))
                0, 1: len = $urandom_range(0, 20);
                2: len = $urandom_range(1, 300);
                3: len = CHUNK_BYTES * $urandom_range(1, 2);
                4: len = $urandom_range(CHUNK_BYTES - 3, CHUNK_BYTES + 3);
                default: len = $urandom_range(200, 700);
            endcase
            full = ((len % CHUNK_BYTES) == 0) ? 0 : CHUNK_BYTES - (len % CHUNK_BYTES);
            full = full + CHUNK_BYTES + 1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: run_image(len, full, $urandom_range(0, 1) * $urandom_range(1, 3));
                6, 7: run_image(len, $urandom_range(0, full), $urandom_range(0, 2));
                default: repeat ($urandom_range(1, 20)) send_req(2'($urandom), 8'($urandom));
            endcase
            if (!drained && sent >= target - RANDOM_REQS / 2)
            begin
                wait_for_results();
                drained = 1'b1;
            end
        end

        calm = 1'b1;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
